// ----- rtl/core/gwgs_pkg.sv -----
// ----------------------------------------------------------------------------
// Geared wrap goal selector package
// Shared widths, types, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package gwgs_pkg;

    localparam int POS_W     = 28;
    localparam int TGT_W     = 23;
    localparam int ORIENT_W  = 20;
    localparam int CFG_IDX_W = 2;

    localparam int PIPE_DEPTH = 11;

    // Two pi in Q16 radians and the gear ratio terms.
    localparam int TWO_PI_Q16 = 411775;
    localparam int GEAR_NUM   = 46;
    localparam int GEAR_DEN   = 130;

    // Reciprocals for the constant divisions: floor(scale * 2^shift / divisor).
    localparam logic [28:0] RECIP_GEAR_DOWN  = 29'd379939414;
    localparam int          SHIFT_GEAR_DOWN  = 30;
    localparam logic [13:0] RECIP_TWO_PI_TGT = 14'd10430;
    localparam int          SHIFT_TWO_PI_TGT = 32;
    localparam logic [17:0] RECIP_TWO_PI_ORI = 18'd166885;
    localparam int          SHIFT_TWO_PI_ORI = 36;
    localparam logic [25:0] RECIP_GEAR_UP    = 26'd47413871;
    localparam int          SHIFT_GEAR_UP    = 24;

    localparam logic signed [POS_W-1:0] ZERO_OFFSET_RST = 28'sd0;
    localparam logic signed [POS_W-1:0] MIN_TRAVEL_RST  = -28'sd104988672;
    localparam logic signed [POS_W-1:0] MAX_TRAVEL_RST  = 28'sd104988672;

    typedef logic signed [POS_W-1:0]    pos_t;
    typedef logic signed [TGT_W-1:0]    tgt_t;
    typedef logic signed [ORIENT_W-1:0] orient_t;
    typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_OFFSET = 2'd0,
        CFG_MIN_TRAVEL  = 2'd1,
        CFG_MAX_TRAVEL  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [PIPE_DEPTH-1:0] valid;
        logic [PIPE_DEPTH-1:0] adv;
    } pipe_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/gwgs_pipe_ctrl.sv -----
// ----------------------------------------------------------------------------
// Geared wrap goal selector pipeline control
// Tracks stage occupancy and decides which stages load in each cycle so that
// bubbles close up behind a stalled output.
// ----------------------------------------------------------------------------
`default_nettype none

module gwgs_pipe_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 out_stall,
    output logic                 in_stall,
    output gwgs_pkg::pipe_ctrl_t ctrl
);
    import gwgs_pkg::*;

    localparam int LAST = PIPE_DEPTH - 1;

    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    logic [PIPE_DEPTH-1:0] adv;

    // A stage loads unless it and every stage after it are full and the output stalls.
    always_comb
    begin
        for (int k = 0; k < PIPE_DEPTH; k++)
        begin
            adv[k] = !out_stall
                || ((valid_reg | ((PIPE_DEPTH'(1) << k) - PIPE_DEPTH'(1))) != '1);
        end
        valid_next[0] = adv[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < PIPE_DEPTH; k++)
        begin
            valid_next[k] = adv[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall   = !adv[0];
    assign ctrl.valid = valid_reg;
    assign ctrl.adv   = adv;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> ((&valid_reg) && out_stall))
        else $error("input stalled while the pipeline has room");

    a_held_stage_keeps_item: assert property (@(posedge clk) disable iff (!rst_n)
        (($past(valid_reg & ~adv) & ~valid_reg) == '0))
        else $error("a held stage lost its item");

    a_one_entry_per_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(valid_reg) <= $past($countones(valid_reg)) + 1))
        else $error("occupancy grew by more than one transfer");

    a_last_stage_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[LAST] && out_stall) |=> valid_reg[LAST])
        else $error("stalled result dropped");

endmodule

`default_nettype wire

// ----- rtl/core/geared_wrap_goal_selector_unit.sv -----
// ----------------------------------------------------------------------------
// Geared wrap goal selector
// Computes the output orientation of a geared servo, forms the direct and the
// opposite-direction goal positions, applies travel limits and picks the
// shorter move.
//
//   Channel  Direction  Handshake               Payload
//   cfg      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//   in       in         in_valid / in_stall     current_position, target_orientation
//   out      out        out_valid / out_stall   current_orientation, goal_position,
//                                               took_wrapped
//
// An item passes through the eleven-stage arithmetic pipeline; one item can enter
// in every cycle unless in_stall is high. cfg_ready is always high; the user must
// write registers only while the block is idle, which the block does not enforce.
// Reset clears the stage valid bits and loads the register reset values.
// A stalled output holds its result while earlier stages keep filling bubbles.
// ----------------------------------------------------------------------------
`default_nettype none

module geared_wrap_goal_selector_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  gwgs_pkg::cfg_idx_t cfg_index,
    input  gwgs_pkg::pos_t     cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  gwgs_pkg::pos_t     current_position,
    input  gwgs_pkg::tgt_t     target_orientation,
    output logic               out_valid,
    input  logic               out_stall,
    output gwgs_pkg::orient_t  current_orientation,
    output gwgs_pkg::pos_t     goal_position,
    output logic               took_wrapped
);
    import gwgs_pkg::*;

    pipe_ctrl_t ctrl;

    pos_t zero_offset_reg;
    pos_t min_travel_reg;
    pos_t max_travel_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_offset_reg <= ZERO_OFFSET_RST;
            min_travel_reg  <= MIN_TRAVEL_RST;
            max_travel_reg  <= MAX_TRAVEL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ZERO_OFFSET: zero_offset_reg <= cfg_data;
                CFG_MIN_TRAVEL:  min_travel_reg  <= cfg_data;
                CFG_MAX_TRAVEL:  max_travel_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    gwgs_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .in_stall  (in_stall),
        .ctrl      (ctrl)
    );

    // Stage 1: offset removal and magnitudes.
    logic signed [POS_W:0] diff_next;
    logic [POS_W:0]        diff_mag;
    logic signed [TGT_W:0] tgt_ext;
    logic [TGT_W:0]        tgt_mag;

    pos_t             s1_pos_reg;
    logic [POS_W-1:0] s1_xd_reg;
    logic             s1_sd_reg;
    logic [TGT_W-1:0] s1_xt_reg;
    logic             s1_st_reg;

    always_comb
    begin
        diff_next = {current_position[POS_W-1], current_position}
            - {zero_offset_reg[POS_W-1], zero_offset_reg};
        diff_mag  = diff_next[POS_W] ? (POS_W+1)'(-diff_next) : (POS_W+1)'(diff_next);
        tgt_ext   = {target_orientation[TGT_W-1], target_orientation};
        tgt_mag   = tgt_ext[TGT_W] ? (TGT_W+1)'(-tgt_ext) : (TGT_W+1)'(tgt_ext);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv[0])
        begin
            s1_pos_reg <= current_position;
            s1_xd_reg  <= diff_mag[POS_W-1:0];
            s1_sd_reg  <= diff_next[POS_W];
            s1_xt_reg  <= tgt_mag[TGT_W-1:0];
            s1_st_reg  <= tgt_ext[TGT_W];
        end
    end

    // Stage 2: reciprocal products for the gear reduction and the target wrap.
    logic [56:0] s2_prod_s_next;
    logic [35:0] s2_prod_t_next;

    pos_t             s2_pos_reg;
    logic [56:0]      s2_prod_s_reg;
    logic [35:0]      s2_prod_t_reg;
    logic [POS_W-1:0] s2_xd_reg;
    logic             s2_sd_reg;
    logic [TGT_W-1:0] s2_xt_reg;
    logic             s2_st_reg;

    always_comb
    begin
        s2_prod_s_next = 57'(s1_xd_reg) * 57'(RECIP_GEAR_DOWN);
        s2_prod_t_next = 36'(s1_xt_reg) * 36'(RECIP_TWO_PI_TGT);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv[1])
        begin
            s2_pos_reg    <= s1_pos_reg;
            s2_prod_s_reg <= s2_prod_s_next;
            s2_prod_t_reg <= s2_prod_t_next;
            s2_xd_reg     <= s1_xd_reg;
            s2_sd_reg     <= s1_sd_reg;
            s2_xt_reg     <= s1_xt_reg;
            s2_st_reg     <= s1_st_reg;
        end
    end

    // Stage 3: quotient corrections.
    logic [26:0]      qs_est;
    logic [33:0]      rem_s;
    logic [33:0]      rem_s_fix;
    logic [26:0]      s3_sm_next;
    logic [3:0]       qt_est;
    logic [TGT_W-1:0] rem_t;
    logic [18:0]      s3_tr_next;

    pos_t        s3_pos_reg;
    logic [26:0] s3_sm_reg;
    logic        s3_sd_reg;
    logic [18:0] s3_tr_reg;
    logic        s3_st_reg;

    always_comb
    begin
        qs_est     = s2_prod_s_reg[SHIFT_GEAR_DOWN +: 27];
        rem_s      = 34'(s2_xd_reg) * 34'(GEAR_NUM) - 34'(qs_est) * 34'(GEAR_DEN);
        s3_sm_next = (rem_s >= 34'(GEAR_DEN)) ? qs_est + 27'd1 : qs_est;
        rem_s_fix  = (rem_s >= 34'(GEAR_DEN)) ? rem_s - 34'(GEAR_DEN) : rem_s;
        qt_est     = s2_prod_t_reg[SHIFT_TWO_PI_TGT +: 4];
        rem_t      = s2_xt_reg - TGT_W'(qt_est) * TGT_W'(TWO_PI_Q16);
        s3_tr_next = (rem_t >= TGT_W'(TWO_PI_Q16))
            ? 19'(rem_t - TGT_W'(TWO_PI_Q16)) : 19'(rem_t);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv[2])
        begin
            s3_pos_reg <= s2_pos_reg;
            s3_sm_reg  <= s3_sm_next;
            s3_sd_reg  <= s2_sd_reg;
            s3_tr_reg  <= s3_tr_next;
            s3_st_reg  <= s2_st_reg;
        end
    end

    // Stage 4: reciprocal product for the orientation wrap; signed target remainder.
    logic [43:0] s4_prod_o_next;
    orient_t     s4_tmod_next;

    pos_t        s4_pos_reg;
    logic [43:0] s4_prod_o_reg;
    logic [26:0] s4_sm_reg;
    logic        s4_sd_reg;
    orient_t     s4_tmod_reg;

    always_comb
    begin
        s4_prod_o_next = 44'(s3_sm_reg) * 44'(RECIP_TWO_PI_ORI);
        s4_tmod_next   = s3_st_reg ? -orient_t'({1'b0, s3_tr_reg})
            : orient_t'({1'b0, s3_tr_reg});
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv[3])
        begin
            s4_pos_reg    <= s3_pos_reg;
            s4_prod_o_reg <= s4_prod_o_next;
            s4_sm_reg     <= s3_sm_reg;
            s4_sd_reg     <= s3_sd_reg;
            s4_tmod_reg   <= s4_tmod_next;
        end
    end

    // Stage 5: orientation remainder magnitude.
    logic [7:0]  qo_est;
    logic [26:0] rem_o;
    logic [18:0] s5_ro_next;

    pos_t        s5_pos_reg;
    logic [18:0] s5_ro_reg;
    logic        s5_sd_reg;
    orient_t     s5_tmod_reg;

    always_comb
    begin
        qo_est     = s4_prod_o_reg[SHIFT_TWO_PI_ORI +: 8];
        rem_o      = s4_sm_reg - 27'(qo_est) * 27'(TWO_PI_Q16);
        s5_ro_next = (rem_o >= 27'(TWO_PI_Q16))
            ? 19'(rem_o - 27'(TWO_PI_Q16)) : 19'(rem_o);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv[4])
        begin
            s5_pos_reg  <= s4_pos_reg;
            s5_ro_reg   <= s5_ro_next;
            s5_sd_reg   <= s4_sd_reg;
            s5_tmod_reg <= s4_tmod_reg;
        end
    end

    // Stage 6: signed orientation and direct delta.
    orient_t            s6_orient_next;
    logic signed [20:0] s6_d1_next;

    pos_t               s6_pos_reg;
    orient_t            s6_orient_reg;
    logic signed [20:0] s6_d1_reg;

    always_comb
    begin
        s6_orient_next = s5_sd_reg ? -orient_t'({1'b0, s5_ro_reg})
            : orient_t'({1'b0, s5_ro_reg});
        s6_d1_next = {s5_tmod_reg[ORIENT_W-1], s5_tmod_reg}
            - {s6_orient_next[ORIENT_W-1], s6_orient_next};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv[5])
        begin
            s6_pos_reg    <= s5_pos_reg;
            s6_orient_reg <= s6_orient_next;
            s6_d1_reg     <= s6_d1_next;
        end
    end

    // Stage 7: opposite-direction delta and delta magnitudes.
    logic signed [20:0] d2;
    logic [20:0]        d1_mag;
    logic [20:0]        d2_mag;

    pos_t        s7_pos_reg;
    orient_t     s7_orient_reg;
    logic [19:0] s7_a1_reg;
    logic [19:0] s7_a2_reg;
    logic        s7_s1_reg;
    logic        s7_s2_reg;

    always_comb
    begin
        d2     = s6_d1_reg[20] ? s6_d1_reg + 21'sd411775 : s6_d1_reg - 21'sd411775;
        d1_mag = s6_d1_reg[20] ? 21'(-s6_d1_reg) : 21'(s6_d1_reg);
        d2_mag = d2[20] ? 21'(-d2) : 21'(d2);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv[6])
        begin
            s7_pos_reg    <= s6_pos_reg;
            s7_orient_reg <= s6_orient_reg;
            s7_a1_reg     <= d1_mag[19:0];
            s7_a2_reg     <= d2_mag[19:0];
            s7_s1_reg     <= s6_d1_reg[20];
            s7_s2_reg     <= d2[20];
        end
    end

    // Stage 8: reciprocal products for the gear step-up.
    logic [45:0] s8_prod1_next;
    logic [45:0] s8_prod2_next;

    pos_t        s8_pos_reg;
    orient_t     s8_orient_reg;
    logic [45:0] s8_prod1_reg;
    logic [45:0] s8_prod2_reg;
    logic [19:0] s8_a1_reg;
    logic [19:0] s8_a2_reg;
    logic        s8_s1_reg;
    logic        s8_s2_reg;

    always_comb
    begin
        s8_prod1_next = 46'(s7_a1_reg) * 46'(RECIP_GEAR_UP);
        s8_prod2_next = 46'(s7_a2_reg) * 46'(RECIP_GEAR_UP);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv[7])
        begin
            s8_pos_reg    <= s7_pos_reg;
            s8_orient_reg <= s7_orient_reg;
            s8_prod1_reg  <= s8_prod1_next;
            s8_prod2_reg  <= s8_prod2_next;
            s8_a1_reg     <= s7_a1_reg;
            s8_a2_reg     <= s7_a2_reg;
            s8_s1_reg     <= s7_s1_reg;
            s8_s2_reg     <= s7_s2_reg;
        end
    end

    // Stage 9: corrected move magnitudes.
    logic [21:0] q1_est;
    logic [21:0] q2_est;
    logic [27:0] rem1;
    logic [27:0] rem2;
    logic [27:0] rem1_fix;
    logic [21:0] s9_m1_next;
    logic [21:0] s9_m2_next;

    pos_t        s9_pos_reg;
    orient_t     s9_orient_reg;
    logic [21:0] s9_m1_reg;
    logic [21:0] s9_m2_reg;
    logic        s9_s1_reg;
    logic        s9_s2_reg;

    always_comb
    begin
        q1_est     = s8_prod1_reg[SHIFT_GEAR_UP +: 22];
        q2_est     = s8_prod2_reg[SHIFT_GEAR_UP +: 22];
        rem1       = 28'(s8_a1_reg) * 28'(GEAR_DEN) - 28'(q1_est) * 28'(GEAR_NUM);
        rem2       = 28'(s8_a2_reg) * 28'(GEAR_DEN) - 28'(q2_est) * 28'(GEAR_NUM);
        s9_m1_next = (rem1 >= 28'(GEAR_NUM)) ? q1_est + 22'd1 : q1_est;
        s9_m2_next = (rem2 >= 28'(GEAR_NUM)) ? q2_est + 22'd1 : q2_est;
        rem1_fix   = (rem1 >= 28'(GEAR_NUM)) ? rem1 - 28'(GEAR_NUM) : rem1;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv[8])
        begin
            s9_pos_reg    <= s8_pos_reg;
            s9_orient_reg <= s8_orient_reg;
            s9_m1_reg     <= s9_m1_next;
            s9_m2_reg     <= s9_m2_next;
            s9_s1_reg     <= s8_s1_reg;
            s9_s2_reg     <= s8_s2_reg;
        end
    end

    // Stage 10: candidate goals and move comparison.
    logic signed [POS_W:0] pos_ext;
    logic signed [POS_W:0] m1_ext;
    logic signed [POS_W:0] m2_ext;
    logic signed [POS_W:0] s10_c1_next;
    logic signed [POS_W:0] s10_c2_next;

    orient_t               s10_orient_reg;
    logic signed [POS_W:0] s10_c1_reg;
    logic signed [POS_W:0] s10_c2_reg;
    logic                  s10_lt_reg;

    always_comb
    begin
        pos_ext     = {s9_pos_reg[POS_W-1], s9_pos_reg};
        m1_ext      = {7'd0, s9_m1_reg};
        m2_ext      = {7'd0, s9_m2_reg};
        s10_c1_next = s9_s1_reg ? pos_ext - m1_ext : pos_ext + m1_ext;
        s10_c2_next = s9_s2_reg ? pos_ext - m2_ext : pos_ext + m2_ext;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv[9])
        begin
            s10_orient_reg <= s9_orient_reg;
            s10_c1_reg     <= s10_c1_next;
            s10_c2_reg     <= s10_c2_next;
            s10_lt_reg     <= (s9_m1_reg < s9_m2_reg);
        end
    end

    // Stage 11: travel limits, choice and saturation into the output register.
    logic signed [POS_W:0] min_ext;
    logic signed [POS_W:0] max_ext;
    logic                  oot1;
    logic                  oot2;
    pos_t                  sat1;
    pos_t                  sat2;
    logic                  out_wrapped_next;
    pos_t                  out_goal_next;

    orient_t out_orient_reg;
    pos_t    out_goal_reg;
    logic    out_wrapped_reg;

    function automatic pos_t saturate(input logic signed [POS_W:0] value);
        pos_t result;
        if (value[POS_W] != value[POS_W-1])
        begin
            result = value[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end
        else
        begin
            result = value[POS_W-1:0];
        end
        return result;
    endfunction

    always_comb
    begin
        min_ext          = {min_travel_reg[POS_W-1], min_travel_reg};
        max_ext          = {max_travel_reg[POS_W-1], max_travel_reg};
        oot1             = (s10_c1_reg > max_ext) || (s10_c1_reg < min_ext);
        oot2             = (s10_c2_reg > max_ext) || (s10_c2_reg < min_ext);
        sat1             = saturate(s10_c1_reg);
        sat2             = saturate(s10_c2_reg);
        out_wrapped_next = oot1 || (!oot2 && !s10_lt_reg);
        out_goal_next    = out_wrapped_next ? sat2 : sat1;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv[10])
        begin
            out_orient_reg  <= s10_orient_reg;
            out_goal_reg    <= out_goal_next;
            out_wrapped_reg <= out_wrapped_next;
        end
    end

    assign out_valid           = ctrl.valid[PIPE_DEPTH-1];
    assign current_orientation = out_orient_reg;
    assign goal_position       = out_goal_reg;
    assign took_wrapped        = out_wrapped_reg;

    a_orient_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((current_orientation < TWO_PI_Q16)
            && (current_orientation > -TWO_PI_Q16)))
        else $error("orientation outside one turn");

    a_gear_down_exact: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.valid[1] |-> (rem_s_fix < 34'(GEAR_DEN)))
        else $error("gear reduction quotient off by more than one");

    a_gear_up_exact: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.valid[7] |-> (rem1_fix < 28'(GEAR_NUM)))
        else $error("gear step-up quotient off by more than one");

endmodule

`default_nettype wire

// ----- tb/sv/gwgs_result_checker.sv -----
// ----------------------------------------------------------------------------
// Geared wrap goal selector result checker
// Watches the configuration, input and output channels of the selector. Each
// input transfer is turned into an expected orientation, goal position and
// path choice by an independent fixed-point predictor, and each output
// transfer is compared field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module gwgs_result_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  gwgs_pkg::cfg_idx_t    cfg_index,
    input  gwgs_pkg::pos_t        cfg_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  gwgs_pkg::pos_t        current_position,
    input  gwgs_pkg::tgt_t        target_orientation,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  gwgs_pkg::orient_t     current_orientation,
    input  gwgs_pkg::pos_t        goal_position,
    input  logic                  took_wrapped,
    output int                    failures = 0,
    output int                    pending = 0,
    output int                    results_seen = 0,
    output int                    wrapped_seen = 0
);
    timeunit 1ns;
    timeprecision 1ps;

    import gwgs_pkg::*;

    localparam longint TWO_PI  = TWO_PI_Q16;
    localparam longint GEAR_DN = GEAR_NUM;
    localparam longint GEAR_UP = GEAR_DEN;
    localparam longint FIELD_HI = 134217727;
    localparam longint FIELD_LO = -134217728;

    typedef struct {
        orient_t orient;
        pos_t    goal;
        logic    wrapped;
    } goal_pick_t;

    goal_pick_t goal_predictions[$];

    longint zero_ofs = ZERO_OFFSET_RST;
    longint min_trv  = MIN_TRAVEL_RST;
    longint max_trv  = MAX_TRAVEL_RST;

    function automatic goal_pick_t predict_goal(pos_t pos, tgt_t tgt);
        longint p;
        longint t;
        longint orient;
        longint d1;
        longint d2;
        longint m1;
        longint m2;
        longint c1;
        longint c2;
        longint a1;
        longint a2;
        longint goal;
        bit     wrap;
        goal_pick_t pick;
        p = pos;
        t = tgt;
        orient = (((p - zero_ofs) * GEAR_DN) / GEAR_UP) % TWO_PI;
        d1 = (t % TWO_PI) - orient;
        d2 = (d1 < 0) ? d1 + TWO_PI : d1 - TWO_PI;
        m1 = (d1 * GEAR_UP) / GEAR_DN;
        m2 = (d2 * GEAR_UP) / GEAR_DN;
        c1 = p + m1;
        c2 = p + m2;
        a1 = (m1 < 0) ? -m1 : m1;
        a2 = (m2 < 0) ? -m2 : m2;
        if (c1 > max_trv || c1 < min_trv)
            wrap = 1'b1;
        else if (c2 > max_trv || c2 < min_trv)
            wrap = 1'b0;
        else
            wrap = !(a1 < a2);
        goal = wrap ? c2 : c1;
        if (goal > FIELD_HI)
            goal = FIELD_HI;
        if (goal < FIELD_LO)
            goal = FIELD_LO;
        pick.orient  = orient_t'(orient);
        pick.goal    = pos_t'(goal);
        pick.wrapped = wrap;
        return pick;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        goal_pick_t want;
        if (!rst_n)
        begin
            zero_ofs = ZERO_OFFSET_RST;
            min_trv  = MIN_TRAVEL_RST;
            max_trv  = MAX_TRAVEL_RST;
            goal_predictions.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ZERO_OFFSET: zero_ofs = cfg_data;
                    CFG_MIN_TRAVEL:  min_trv  = cfg_data;
                    CFG_MAX_TRAVEL:  max_trv  = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                goal_predictions.push_back(predict_goal(current_position, target_orientation));
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (took_wrapped)
                    wrapped_seen++;
                if (goal_predictions.size() == 0)
                begin
                    $error("Result transfer arrived with no item outstanding.");
                    failures++;
                end
                else
                begin
                    want = goal_predictions.pop_front();
                    if (current_orientation !== want.orient)
                    begin
                        $error("current_orientation: expected %0d, got %0d",
                               want.orient, current_orientation);
                        failures++;
                    end
                    if (goal_position !== want.goal)
                    begin
                        $error("goal_position: expected %0d, got %0d",
                               want.goal, goal_position);
                        failures++;
                    end
                    if (took_wrapped !== want.wrapped)
                    begin
                        $error("took_wrapped: expected %0d, got %0d",
                               want.wrapped, took_wrapped);
                        failures++;
                    end
                end
            end
            pending = goal_predictions.size();
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// Geared wrap goal selector testbench
// Drives directed corner items and biased random items through the selector
// under several travel-limit and zero-offset settings, including full-range,
// inverted and single-point limits, with bursty input traffic and random
// output stalls. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gwgs_pkg::*;

    localparam pos_t     POS_HI    = 28'sh7FFFFFF;
    localparam pos_t     POS_LO    = pos_t'(28'h8000000);
    localparam tgt_t     TGT_HI    = 23'sh3FFFFF;
    localparam tgt_t     TGT_LO    = tgt_t'(23'h400000);
    localparam cfg_idx_t CFG_SPARE = 2'd3;
    localparam int       HALF_TURN = TWO_PI_Q16 / 2;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    cfg_idx_t cfg_index = '0;
    pos_t     cfg_data = '0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    pos_t     current_position = '0;
    tgt_t     target_orientation = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    orient_t  current_orientation;
    pos_t     goal_position;
    logic     took_wrapped;

    int failures;
    int pending;
    int results_seen;
    int wrapped_seen;

    pos_t zero_set = ZERO_OFFSET_RST;
    pos_t lo_set   = MIN_TRAVEL_RST;
    pos_t hi_set   = MAX_TRAVEL_RST;

    int items_sent = 0;
    int reg_writes = 0;
    int burst_left = 0;
    int stall_left = 0;
    int stall_mode = 0;

    geared_wrap_goal_selector_unit u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .current_position    (current_position),
        .target_orientation  (target_orientation),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .current_orientation (current_orientation),
        .goal_position       (goal_position),
        .took_wrapped        (took_wrapped)
    );

    gwgs_result_checker u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .current_position    (current_position),
        .target_orientation  (target_orientation),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .current_orientation (current_orientation),
        .goal_position       (goal_position),
        .took_wrapped        (took_wrapped),
        .failures            (failures),
        .pending             (pending),
        .results_seen        (results_seen),
        .wrapped_seen        (wrapped_seen)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(8, 60);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 1) == 1);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= (stall_left % 5 < 2);
        endcase
    end

    initial
    begin
        #5_000_000;
        $display("FAIL geared_wrap_goal_selector_unit");
        $finish;
    end

    task automatic write_reg(cfg_idx_t idx, pos_t value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ZERO_OFFSET: zero_set = value;
            CFG_MIN_TRAVEL:  lo_set   = value;
            CFG_MAX_TRAVEL:  hi_set   = value;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic set_limits(pos_t zero, pos_t lo, pos_t hi);
        write_reg(CFG_ZERO_OFFSET, zero);
        write_reg(CFG_MIN_TRAVEL, lo);
        write_reg(CFG_MAX_TRAVEL, hi);
    endtask

    task automatic send_item(pos_t pos, tgt_t tgt);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        @(negedge clk);
        in_valid           <= 1'b1;
        current_position   <= pos;
        target_orientation <= tgt;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH + 4) @(negedge clk);
    endtask

    function automatic pos_t rand_position();
        case ($urandom_range(0, 3))
            0: return pos_t'($urandom);
            1: return hi_set - pos_t'($urandom_range(0, 1500000));
            2: return lo_set + pos_t'($urandom_range(0, 1500000));
            default: return zero_set + pos_t'(int'($urandom_range(0, 3000000)) - 1500000);
        endcase
    endfunction

    function automatic tgt_t rand_target();
        if ($urandom_range(0, 1) == 0)
            return tgt_t'($urandom);
        return tgt_t'(int'($urandom_range(0, 2 * TWO_PI_Q16)) - TWO_PI_Q16);
    endfunction

    task automatic run_random(int count);
        repeat (count)
            send_item(rand_position(), rand_target());
    endtask

    initial
    begin
        pos_t lo;
        pos_t hi;
        pos_t pin;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Corners under the reset limits.
        send_item('0, '0);
        send_item(POS_HI, TGT_HI);
        send_item(POS_LO, TGT_LO);
        send_item(POS_HI, TGT_LO);
        send_item(POS_LO, TGT_HI);
        send_item('0, tgt_t'(TWO_PI_Q16));
        send_item('0, tgt_t'(-TWO_PI_Q16));
        send_item('0, tgt_t'(TWO_PI_Q16 - 1));
        send_item('0, tgt_t'(1 - TWO_PI_Q16));
        send_item('0, tgt_t'(HALF_TURN));
        send_item('0, tgt_t'(HALF_TURN + 1));
        send_item('0, tgt_t'(-HALF_TURN));
        send_item('0, tgt_t'(-HALF_TURN - 1));
        send_item(MAX_TRAVEL_RST, tgt_t'(100000));
        send_item(pos_t'(MAX_TRAVEL_RST - 10), tgt_t'(-100000));
        send_item(MIN_TRAVEL_RST, tgt_t'(-100000));
        send_item(MIN_TRAVEL_RST, tgt_t'(100000));
        send_item(pos_t'(120000000), '0);
        send_item(pos_t'(-120000000), tgt_t'(300000));
        send_item(pos_t'(-1), tgt_t'(-1));
        run_random(100);
        wait_idle();

        lo = pos_t'($urandom);
        hi = pos_t'($urandom);
        if (lo > hi)
        begin
            pin = lo;
            lo  = hi;
            hi  = pin;
        end
        set_limits(pos_t'($urandom), lo, hi);
        run_random(90);
        wait_idle();

        // Full-range limits: candidates past the field edge are refused.
        set_limits(POS_HI, POS_LO, POS_HI);
        send_item(POS_HI, TGT_HI);
        send_item(POS_LO, TGT_LO);
        send_item(POS_HI, '0);
        send_item(POS_LO, '0);
        run_random(70);
        wait_idle();

        // Inverted limits always take the wrapped path, saturating at the edges.
        set_limits(POS_LO, POS_HI, POS_LO);
        write_reg(CFG_SPARE, pos_t'($urandom));
        repeat (6)
            send_item(POS_LO + pos_t'($urandom_range(0, 8)), rand_target());
        repeat (6)
            send_item(POS_HI - pos_t'($urandom_range(0, 8)), rand_target());
        run_random(70);
        wait_idle();

        pin = pos_t'($urandom);
        set_limits(pos_t'($urandom), pin, pin);
        send_item(pin, '0);
        run_random(40);
        wait_idle();

        set_limits(ZERO_OFFSET_RST, MIN_TRAVEL_RST, MAX_TRAVEL_RST);
        run_random(30);
        wait_idle();

        $display("Sent %0d items across six limit settings with %0d register writes.",
                 items_sent, reg_writes);
        $display("Checked %0d results; %0d chose the opposite-direction path.",
                 results_seen, wrapped_seen);
        if (failures == 0)
            $display("PASS geared_wrap_goal_selector_unit");
        else
            $display("FAIL geared_wrap_goal_selector_unit");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/gwgs_pkg.sv
rtl/core/gwgs_pipe_ctrl.sv
rtl/core/geared_wrap_goal_selector_unit.sv
tb/sv/gwgs_result_checker.sv
tb/sv/testbench.sv
